// File: rtl/pvc_pkg.sv
// ----------------------------------------------------------------------------
// Petroleum volume correction package
// Shared widths, band codes, band constants and reciprocal multipliers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pvc_pkg;

   // Field widths of the request and response beats.
   localparam int DENSITY_W = 14;
   localparam int TEMP_W    = 15;
   localparam int VCF_W     = 16;

   // Density bands.
   typedef enum logic [1:0] {
      BAND_HEAVY   = 2'd0,
      BAND_MIDDLE  = 2'd1,
      BAND_TRANS   = 2'd2,
      BAND_DEFAULT = 2'd3
   } band_type;

   // Clamp limits of the inputs.
   localparam logic [DENSITY_W-1:0]      DENS_MIN = 14'd5000;
   localparam logic [DENSITY_W-1:0]      DENS_MAX = 14'd15000;
   localparam logic signed [TEMP_W-1:0]  TEMP_MIN = -15'sd5000;
   localparam logic signed [TEMP_W-1:0]  TEMP_MAX = 15'sd15000;
   localparam logic signed [TEMP_W-1:0]  TEMP_REF = 15'sd1500;

   // Quotient bits of the alpha dividers and their numerator widths.
   localparam int QUO_W     = 31;
   localparam int K0_W      = 25;
   localparam int K1_W      = 13;
   localparam int FRAC_W    = 38;
   localparam int NUM_SQ_W  = K0_W + FRAC_W;
   localparam int NUM_LIN_W = K1_W + FRAC_W;
   localparam int DEN_SQ_W  = 35;
   localparam int DEN_LIN_W = 24;

   // Number of series terms of the exponential.
   localparam int EXP_TERMS = 12;

   // Datapath widths of the series.
   localparam int V_W    = 32;
   localparam int TERM_W = 32;
   localparam int SUM_W  = 33;

   // One in Q30.
   localparam logic signed [TERM_W-1:0] Q30_ONE = 32'sh4000_0000;

   // Constant part of alpha for the transition band, in Q38.
   localparam logic [31:0] NEG_A_TRANS =
      32'(((64'd336312 << 38) + 64'd50000000) / 64'd100000000);

   // Reciprocal of 25 for values below 2^22, shift 27.
   localparam int          M25_SH = 27;
   localparam logic [22:0] M25    = 23'(((64'd1 << M25_SH) + 64'd24) / 64'd25);

   // Reciprocal of 5 for values below 2^31, shift 34.
   localparam int          M5_SH = 34;
   localparam logic [31:0] M5    = 32'(((64'd1 << M5_SH) + 64'd4) / 64'd5);

   // Sort a clamped density into its band.
   function automatic band_type band_of(input logic [DENSITY_W-1:0] d);
      band_type b;
      if (d > 14'd8390 && d < 14'd10750) begin
         b = BAND_HEAVY;
      end else if (d > 14'd7880 && d < 14'd8385) begin
         b = BAND_MIDDLE;
      end else if (d > 14'd7705 && d < 14'd7875) begin
         b = BAND_TRANS;
      end else begin
         b = BAND_DEFAULT;
      end
      return b;
   endfunction

   // K0 of each band in units of 1e-4.
   function automatic logic [K0_W-1:0] band_k0(input band_type b);
      logic [K0_W-1:0] k;
      unique case (b)
         BAND_HEAVY:  k = 25'd1869696;
         BAND_MIDDLE: k = 25'd5945418;
         BAND_TRANS:  k = 25'd26803206;
         default:     k = 25'd3464228;
      endcase
      return k;
   endfunction

   // K1 of each band in units of 1e-4.
   function automatic logic [K1_W-1:0] band_k1(input band_type b);
      logic [K1_W-1:0] k;
      unique case (b)
         BAND_HEAVY:   k = 13'd4862;
         BAND_DEFAULT: k = 13'd4388;
         default:      k = 13'd0;
      endcase
      return k;
   endfunction

   // Negated constant term of alpha in Q38.
   function automatic logic [31:0] band_na(input band_type b);
      logic [31:0] a;
      unique case (b)
         BAND_TRANS: a = NEG_A_TRANS;
         default:    a = 32'd0;
      endcase
      return a;
   endfunction

   // Pipeline tag that travels next to the datapath.
   typedef struct packed {
      logic                     valid;
      band_type                 band;
      logic signed [TEMP_W-1:0] dt;
   } pipe_type;

endpackage

// File: rtl/pvc_if.sv
// ----------------------------------------------------------------------------
// Petroleum volume correction channels
// Valid/ready channels for request beats and response beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pvc_req_if
   import pvc_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic [DENSITY_W-1:0]     density;
   logic signed [TEMP_W-1:0] temperature;

   modport source (output valid, density, temperature, input ready);
   modport sink (input valid, density, temperature, output ready);
endinterface

interface pvc_rsp_if
   import pvc_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [VCF_W-1:0] vcf;
   band_type         band;

   modport source (output valid, vcf, band, input ready);
   modport sink (input valid, vcf, band, output ready);
endinterface

// File: rtl/pvc_div_cell.sv
// ----------------------------------------------------------------------------
// Divider cell
// One restoring step: shifts in one numerator bit and yields one quotient bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pvc_div_cell
   import pvc_pkg::*;
#(
   parameter int DEN_W = 35,
   parameter int QUO_W = 31
) (
   input  logic             clock,
   input  logic             adv,
   input  logic [DEN_W-1:0] src_rem,
   input  logic [QUO_W-1:0] src_work,
   input  logic [DEN_W-1:0] src_den,
   output logic [DEN_W-1:0] dst_rem,
   output logic [QUO_W-1:0] dst_work,
   output logic [DEN_W-1:0] dst_den
);

   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0] work_ff, work_in;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             ge;

   // Trial subtraction of the divisor from the shifted remainder.
   always_comb begin
      trial   = {src_rem, src_work[QUO_W-1]};
      diff    = trial - (DEN_W+1)'(src_den);
      ge      = trial >= (DEN_W+1)'(src_den);
      rem_in  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      work_in = {src_work[QUO_W-2:0], ge};
   end

   // Step register.
   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff  <= rem_in;
         work_ff <= work_in;
         den_ff  <= src_den;
      end
   end

   assign dst_rem  = rem_ff;
   assign dst_work = work_ff;
   assign dst_den  = den_ff;

endmodule

// File: rtl/pvc_div.sv
// ----------------------------------------------------------------------------
// Pipelined divider
// A row of restoring cells, one quotient bit per cell and cycle while adv is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pvc_div
   import pvc_pkg::*;
#(
   parameter int NUM_W = 63,
   parameter int DEN_W = 35,
   parameter int QUO_W = 31
) (
   input  logic             clock,
   input  logic             adv,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [QUO_W-1:0] quo
);

   logic [DEN_W-1:0] rem_ch  [QUO_W+1];
   logic [QUO_W-1:0] work_ch [QUO_W+1];
   logic [DEN_W-1:0] den_ch  [QUO_W+1];

   // The upper numerator bits form the first partial remainder.
   assign rem_ch[0]  = DEN_W'(num[NUM_W-1:QUO_W]);
   assign work_ch[0] = num[QUO_W-1:0];
   assign den_ch[0]  = den;

   for (genvar i = 0; i < QUO_W; i++) begin : g_cell
      pvc_div_cell #(
         .DEN_W (DEN_W),
         .QUO_W (QUO_W)
      ) u_cell (
         .clock    (clock),
         .adv      (adv),
         .src_rem  (rem_ch[i]),
         .src_work (work_ch[i]),
         .src_den  (den_ch[i]),
         .dst_rem  (rem_ch[i+1]),
         .dst_work (work_ch[i+1]),
         .dst_den  (den_ch[i+1])
      );
   end

   assign quo = work_ch[QUO_W];

endmodule

// File: rtl/pvc_exp_cell.sv
// ----------------------------------------------------------------------------
// Series cell
// Forms term k = round(term(k-1) * v / k) and accumulates the previous term.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pvc_exp_cell
   import pvc_pkg::*;
#(
   parameter int K = 1
) (
   input  logic                     clock,
   input  logic                     adv,
   input  logic signed [V_W-1:0]    src_v,
   input  logic signed [TERM_W-1:0] src_term,
   input  logic signed [SUM_W-1:0]  src_sum,
   output logic signed [V_W-1:0]    dst_v,
   output logic signed [TERM_W-1:0] dst_term,
   output logic signed [SUM_W-1:0]  dst_sum
);

   localparam int          SH    = 31 + $clog2(K);
   localparam int          HALF  = K / 2;
   localparam logic [31:0] RECIP = 32'(((64'd1 << SH) + 64'(K) - 64'd1) / 64'(K));

   logic [31:0]              tmag, vmag;
   logic [63:0]              prod;
   logic [30:0]              p_ff, p_in;
   logic                     neg_ff, neg_in;
   logic signed [V_W-1:0]    va_ff;
   logic signed [SUM_W-1:0]  suma_ff, suma_in;
   logic [30:0]              a;
   logic [62:0]              qprod;
   logic [30:0]              qk;
   logic signed [V_W-1:0]    v_ff;
   logic signed [TERM_W-1:0] term_ff, term_in;
   logic signed [SUM_W-1:0]  sum_ff;

   // First half: rounded Q30 product of magnitudes, and the running sum.
   always_comb begin
      tmag    = src_term[TERM_W-1] ? 32'(-src_term) : 32'(src_term);
      vmag    = src_v[V_W-1] ? 32'(-src_v) : 32'(src_v);
      prod    = 64'(tmag) * 64'(vmag);
      p_in    = 31'((prod + 64'h2000_0000) >> 30);
      neg_in  = src_term[TERM_W-1] ^ src_v[V_W-1];
      suma_in = src_sum + SUM_W'(src_term);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_ff    <= p_in;
         neg_ff  <= neg_in;
         va_ff   <= src_v;
         suma_ff <= suma_in;
      end
   end

   // Second half: rounded division by K through its reciprocal.
   always_comb begin
      a       = 31'(p_ff + 31'(HALF));
      qprod   = 63'(a) * 63'(RECIP);
      qk      = 31'(qprod >> SH);
      term_in = neg_ff ? -signed'(TERM_W'(qk)) : signed'(TERM_W'(qk));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         v_ff    <= va_ff;
         term_ff <= term_in;
         sum_ff  <= suma_ff;
      end
   end

   assign dst_v    = v_ff;
   assign dst_term = term_ff;
   assign dst_sum  = sum_ff;

endmodule

// File: rtl/petroleum_volume_correction_unit.sv
// Throughput: one beat per cycle; the whole pipeline advances together and
// holds while a response beat waits and rsp_if.ready is low.
// Depth is set by the two 31-cell alpha dividers and the 12-cell series.
// Reset clears the valid bits of all stages; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Petroleum volume correction unit
// Density band lookup, alpha by pipelined division, and exp() by a series.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module petroleum_volume_correction_unit
   import pvc_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   pvc_req_if.sink   req_if,
   pvc_rsp_if.source rsp_if
);

   localparam int DIV_TAP   = 1 + QUO_W;
   localparam int ALPHA_TAP = DIV_TAP + 1;
   localparam int DEPTH     = 2 + QUO_W + 6 + 2 * EXP_TERMS + 1;

   logic     adv;
   pipe_type pipe_ff [DEPTH];
   pipe_type pipe_in;

   // Stage one.
   logic [DENSITY_W-1:0]     d_clamp;
   logic signed [TEMP_W-1:0] t_clamp;
   logic [27:0]              d2_ff, d2_in;
   logic [23:0]              d1k_ff, d1k_in;

   // Stage two.
   logic [NUM_SQ_W-1:0]  num_sq_ff, num_sq_in;
   logic [DEN_SQ_W-1:0]  den_sq_ff, den_sq_in;
   logic [NUM_LIN_W-1:0] num_lin_ff, num_lin_in;
   logic [DEN_LIN_W-1:0] den_lin_ff;

   // Divider results.
   logic [QUO_W-1:0] quo_sq, quo_lin;

   // Alpha and x = alpha * dT.
   logic signed [31:0] alpha_ff, alpha_in;
   logic signed [46:0] prod;
   logic [43:0]        m_ff, m_in;
   logic               neg_m_ff;
   logic [44:0]        asum;
   logic [16:0]        a_hi;
   logic [39:0]        qh_prod;
   logic [12:0]        qh_ff, qh_in;
   logic [4:0]         rh_ff, rh_in;
   logic [16:0]        alo_ff;
   logic               neg_a_ff;
   logic [21:0]        r_low;
   logic [44:0]        ql_prod;
   logic [29:0]        xm_ff, xm_in;
   logic               neg_x_ff;
   logic [59:0]        sq_ff, sq_in;
   logic [29:0]        xm2_ff;
   logic               neg_s_ff;
   logic [62:0]        n_sq;
   logic [30:0]        a5;
   logic [62:0]        q_prod;
   logic [28:0]        q_val;
   logic signed [V_W-1:0] v_ff, v_in;

   // Series chain.
   logic signed [V_W-1:0]    v_ch    [EXP_TERMS+1];
   logic signed [TERM_W-1:0] term_ch [EXP_TERMS+1];
   logic signed [SUM_W-1:0]  sum_ch  [EXP_TERMS+1];

   // Output stage.
   logic signed [SUM_W-1:0] sum_fin;
   logic [SUM_W-1:0]        sum_pos;
   logic [SUM_W-1:0]        res;
   logic [VCF_W-1:0]        vcf_ff, vcf_in;

   // The pipeline moves whenever the output register is free or being read.
   assign adv          = !pipe_ff[DEPTH-1].valid || rsp_if.ready;
   assign req_if.ready = adv;

   // Input clamp, band lookup and first products.
   always_comb begin
      d_clamp = req_if.density;
      if (req_if.density < DENS_MIN) begin
         d_clamp = DENS_MIN;
      end else if (req_if.density > DENS_MAX) begin
         d_clamp = DENS_MAX;
      end
      t_clamp = req_if.temperature;
      if (req_if.temperature < TEMP_MIN) begin
         t_clamp = TEMP_MIN;
      end else if (req_if.temperature > TEMP_MAX) begin
         t_clamp = TEMP_MAX;
      end
      pipe_in.valid = req_if.valid;
      pipe_in.band  = band_of(d_clamp);
      pipe_in.dt    = t_clamp - TEMP_REF;
      d2_in         = 28'(d_clamp) * 28'(d_clamp);
      d1k_in        = 24'(d_clamp) * 24'd1000;
   end

   // Tag shift line; only the valid bits are reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            pipe_ff[i].valid <= 1'b0;
         end
      end else if (adv) begin
         pipe_ff[0] <= pipe_in;
         for (int i = 1; i < DEPTH; i++) begin
            pipe_ff[i] <= pipe_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d2_ff  <= d2_in;
         d1k_ff <= d1k_in;
      end
   end

   // Divider operands; the rounding half lands in the empty fraction bits.
   always_comb begin
      den_sq_in  = DEN_SQ_W'(d2_ff) * DEN_SQ_W'(100);
      num_sq_in  = {band_k0(pipe_ff[0].band), FRAC_W'(den_sq_in >> 1)};
      num_lin_in = {band_k1(pipe_ff[0].band), FRAC_W'(d1k_ff >> 1)};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         num_sq_ff  <= num_sq_in;
         den_sq_ff  <= den_sq_in;
         num_lin_ff <= num_lin_in;
         den_lin_ff <= d1k_ff;
      end
   end

   // K0 / D^2 term.
   pvc_div #(
      .NUM_W (NUM_SQ_W),
      .DEN_W (DEN_SQ_W),
      .QUO_W (QUO_W)
   ) u_div_sq (
      .clock (clock),
      .adv   (adv),
      .num   (num_sq_ff),
      .den   (den_sq_ff),
      .quo   (quo_sq)
   );

   // K1 / D term.
   pvc_div #(
      .NUM_W (NUM_LIN_W),
      .DEN_W (DEN_LIN_W),
      .QUO_W (QUO_W)
   ) u_div_lin (
      .clock (clock),
      .adv   (adv),
      .num   (num_lin_ff),
      .den   (den_lin_ff),
      .quo   (quo_lin)
   );

   // Alpha in Q38.
   assign alpha_in = signed'(32'(quo_sq) + 32'(quo_lin) - band_na(pipe_ff[DIV_TAP].band));

   always_ff @(posedge clock) begin
      if (adv) begin
         alpha_ff <= alpha_in;
      end
   end

   // Magnitude of alpha * dT.
   always_comb begin
      prod = 47'(alpha_ff) * 47'(pipe_ff[ALPHA_TAP].dt);
      m_in = prod[46] ? 44'(-prod) : 44'(prod);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_ff     <= m_in;
         neg_m_ff <= prod[46];
      end
   end

   // Rounded division by 25600: shift by 1024, then divide the upper part by 25.
   always_comb begin
      asum    = 45'(m_ff) + 45'd12800;
      a_hi    = asum[43:27];
      qh_prod = 40'(a_hi) * 40'(M25);
      qh_in   = 13'(qh_prod >> M25_SH);
      rh_in   = 5'(a_hi - 17'(qh_in) * 17'd25);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         qh_ff    <= qh_in;
         rh_ff    <= rh_in;
         alo_ff   <= asum[26:10];
         neg_a_ff <= neg_m_ff;
      end
   end

   // Lower part of the division by 25.
   always_comb begin
      r_low   = {rh_ff, alo_ff};
      ql_prod = 45'(r_low) * 45'(M25);
      xm_in   = {qh_ff, 17'(ql_prod >> M25_SH)};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         xm_ff    <= xm_in;
         neg_x_ff <= neg_a_ff;
      end
   end

   // Square of x.
   assign sq_in = 60'(xm_ff) * 60'(xm_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_ff    <= sq_in;
         xm2_ff   <= xm_ff;
         neg_s_ff <= neg_x_ff;
      end
   end

   // q = round(0.8 * x^2), then v = -(x + q).
   always_comb begin
      n_sq   = {1'b0, sq_ff, 2'b00} + 63'(64'd5 << 29);
      a5     = n_sq[60:30];
      q_prod = 63'(a5) * 63'(M5);
      q_val  = 29'(q_prod >> M5_SH);
      if (neg_s_ff) begin
         v_in = signed'(32'(xm2_ff) - 32'(q_val));
      end else begin
         v_in = -signed'(32'(xm2_ff) + 32'(q_val));
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         v_ff <= v_in;
      end
   end

   // Series cells; the sum is one term behind the term it carries.
   assign v_ch[0]    = v_ff;
   assign term_ch[0] = Q30_ONE;
   assign sum_ch[0]  = '0;

   for (genvar i = 0; i < EXP_TERMS; i++) begin : g_term
      pvc_exp_cell #(
         .K (i + 1)
      ) u_cell (
         .clock    (clock),
         .adv      (adv),
         .src_v    (v_ch[i]),
         .src_term (term_ch[i]),
         .src_sum  (sum_ch[i]),
         .dst_v    (v_ch[i+1]),
         .dst_term (term_ch[i+1]),
         .dst_sum  (sum_ch[i+1])
      );
   end

   // Final sum, rounding to Q15 and saturation.
   always_comb begin
      sum_fin = sum_ch[EXP_TERMS] + SUM_W'(term_ch[EXP_TERMS]);
      sum_pos = sum_fin[SUM_W-1] ? '0 : SUM_W'(sum_fin);
      res     = (sum_pos + SUM_W'(1 << 14)) >> 15;
      vcf_in  = (res > SUM_W'(16'hFFFF)) ? 16'hFFFF : res[VCF_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         vcf_ff <= vcf_in;
      end
   end

   assign rsp_if.valid = pipe_ff[DEPTH-1].valid;
   assign rsp_if.band  = pipe_ff[DEPTH-1].band;
   assign rsp_if.vcf   = vcf_ff;

endmodule

// File: test/petroleum_volume_correction_unit_tb.sv
// ----------------------------------------------------------------------------
// Petroleum volume correction unit testbench
// Sends density and temperature beats through random gaps and stalls. A
// built-in fixed-point model predicts each band and correction factor, and
// every response beat is checked in order against that prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module petroleum_volume_correction_unit_tb;
   import pvc_pkg::*;

   localparam int LATENCY     = 64;
   localparam int STALL_LIMIT = 20000;

   typedef struct {
      logic [VCF_W-1:0] vcf;
      band_type         band;
   } vcf_result_type;

   logic clock;
   logic reset;

   pvc_req_if req_if ();
   pvc_rsp_if rsp_if ();

   petroleum_volume_correction_unit i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source)
   );

   vcf_result_type pending_vcf[$];
   int             error_count;
   int             idle_cycles;
   bit             hold_rsp;
   int             hold_rsp_cycles;

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Rounded division of a magnitude, half away from zero.
   function automatic longint unsigned div_round(input longint unsigned num,
                                                 input longint unsigned den);
      return (num + den / 2) / den;
   endfunction

   function automatic longint sdiv_round(input longint num, input longint unsigned den);
      longint unsigned mag;
      longint unsigned r;
      mag = (num < 0) ? longint'(-num) : num;
      r   = div_round(mag, den);
      return (num < 0) ? -longint'(r) : longint'(r);
   endfunction

   // Rounded Q30 product.
   function automatic longint q30_mul(input longint a, input longint b);
      longint unsigned ma;
      longint unsigned mb;
      longint unsigned p;
      ma = (a < 0) ? longint'(-a) : a;
      mb = (b < 0) ? longint'(-b) : b;
      p  = (ma * mb + (64'd1 << 29)) >> 30;
      return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
   endfunction

   // Predicts the band and correction factor of one request beat.
   function automatic vcf_result_type predict_vcf(input logic [DENSITY_W-1:0] density,
                                                  input logic signed [TEMP_W-1:0] temp);
      vcf_result_type  r;
      longint unsigned d;
      longint          t;
      longint unsigned k0;
      longint unsigned k1;
      longint unsigned na;
      longint          alpha;
      longint          x;
      longint unsigned xm;
      longint          v;
      longint          term;
      longint          sum;
      longint unsigned res;
      d = density;
      t = temp;
      if (d < 5000) d = 5000;
      if (d > 15000) d = 15000;
      if (t < -5000) t = -5000;
      if (t > 15000) t = 15000;
      if (d > 8390 && d < 10750) r.band = BAND_HEAVY;
      else if (d > 7880 && d < 8385) r.band = BAND_MIDDLE;
      else if (d > 7705 && d < 7875) r.band = BAND_TRANS;
      else r.band = BAND_DEFAULT;
      case (r.band)
         BAND_HEAVY:  begin k0 = 1869696;  k1 = 4862; na = 0;      end
         BAND_MIDDLE: begin k0 = 5945418;  k1 = 0;    na = 0;      end
         BAND_TRANS:  begin k0 = 26803206; k1 = 0;    na = 336312; end
         default:     begin k0 = 3464228;  k1 = 4388; na = 0;      end
      endcase
      alpha = div_round(k0 << 38, 100 * d * d);
      alpha += div_round(k1 << 38, 1000 * d);
      alpha -= div_round(na << 38, 100000000);
      x  = sdiv_round(alpha * (t - 1500), 25600);
      xm = (x < 0) ? longint'(-x) : x;
      v  = -(x + longint'(div_round(xm * xm * 4, 64'd5 << 30)));
      sum  = 64'sd1 << 30;
      term = 64'sd1 << 30;
      for (int k = 1; k <= EXP_TERMS; k++) begin
         term = sdiv_round(q30_mul(term, v), k);
         sum += term;
      end
      if (sum < 0) sum = 0;
      res = (longint'(sum) + (64'd1 << 14)) >> 15;
      if (res > 65535) res = 65535;
      r.vcf = res[VCF_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Sends one request beat after a random gap and records its prediction.
   // Valid stays high after the beat so that a following beat can go back to back.
   task automatic send_reading(input logic [DENSITY_W-1:0] density,
                               input logic signed [TEMP_W-1:0] temp);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if ($urandom_range(0, 2) == 0) gap = 0;
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.density     <= density;
      req_if.temperature <= temp;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      pending_vcf.push_back(predict_vcf(density, temp));
      @(negedge clock);
   endtask

   // Drops the request and waits until every expected response has arrived.
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      @(negedge clock);
      while (pending_vcf.size() != 0) @(negedge clock);
   endtask

   // Clamp edges, band borders and field extremes.
   task automatic test_directed();
      logic [DENSITY_W-1:0] dens[] = '{14'd0, 14'd4999, 14'd5000, 14'd7705, 14'd7706,
         14'd7874, 14'd7875, 14'd7880, 14'd7881, 14'd8384, 14'd8385, 14'd8390,
         14'd8391, 14'd10749, 14'd10750, 14'd15000, 14'd15001, 14'h3fff};
      logic signed [TEMP_W-1:0] temps[] = '{15'sh4000, -15'sd5001, -15'sd5000,
         15'sd1500, 15'sd15000, 15'sd15001, 15'sd16383};
      foreach (dens[i]) send_reading(dens[i], 15'sd4000);
      foreach (temps[i]) send_reading(14'd5000, temps[i]);
   endtask

   // Random readings, mostly within the field ranges.
   task automatic test_random(input int count);
      logic [DENSITY_W-1:0]     d;
      logic signed [TEMP_W-1:0] t;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            d = DENSITY_W'($urandom);
            t = TEMP_W'($urandom);
         end else begin
            d = DENSITY_W'($urandom_range(5000, 15000));
            t = TEMP_W'($signed($urandom_range(0, 20000)) - 5000);
         end
         send_reading(d, t);
      end
   endtask

   // The receiver stalls for a long stretch while beats keep coming.
   task automatic test_backpressure();
      hold_rsp_cycles = 300;
      hold_rsp        = 1'b1;
      for (int i = 0; i < 120; i++) begin
         req_if.valid       <= 1'b1;
         req_if.density     <= DENSITY_W'($urandom_range(5000, 15000));
         req_if.temperature <= TEMP_W'($signed($urandom_range(0, 20000)) - 5000);
         @(posedge clock);
         while (!req_if.ready) @(posedge clock);
         pending_vcf.push_back(predict_vcf(req_if.density, req_if.temperature));
         @(negedge clock);
      end
      wait_drained();
   endtask

   // Response side: random stalls, a long hold on request, and the check.
   initial begin
      vcf_result_type exp_r;
      int             stall;
      rsp_if.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_if.ready <= 1'b0;
            repeat (hold_rsp_cycles) @(negedge clock);
            hold_rsp = 1'b0;
         end
         stall = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : 0;
         if (stall != 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_if.valid) @(posedge clock);
         if (pending_vcf.size() == 0) begin
            report_mismatch("response beat with no request outstanding");
         end else begin
            exp_r = pending_vcf.pop_front();
            if (rsp_if.vcf !== exp_r.vcf)
               report_mismatch($sformatf("vcf %0d, expected %0d", rsp_if.vcf, exp_r.vcf));
            if (rsp_if.band !== exp_r.band)
               report_mismatch($sformatf("band %0d, expected %0d", rsp_if.band, exp_r.band));
         end
         @(negedge clock);
      end
   end

   // Watchdog on cycles without any accepted beat.
   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // Test sequence.
   initial begin
      error_count        = 0;
      hold_rsp           = 1'b0;
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.density     = '0;
      req_if.temperature = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      wait_drained();
      test_random(600);
      test_backpressure();
      test_random(600);
      wait_drained();
      repeat (LATENCY + 20) @(negedge clock);
      if (error_count == 0 && pending_vcf.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/pvc_pkg.sv
rtl/pvc_if.sv
rtl/pvc_div_cell.sv
rtl/pvc_div.sv
rtl/pvc_exp_cell.sv
rtl/petroleum_volume_correction_unit.sv
test/petroleum_volume_correction_unit_tb.sv
